// ===== rtl/core/timed_wait_list_macros.svh =====
// Assertion macros used by the timed wait list checker.
`ifndef TIMED_WAIT_LIST_MACROS_SVH
`define TIMED_WAIT_LIST_MACROS_SVH

// Concurrent assertion on clk_i, held off while rst_ni is low.
`define TWL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication built on the macro above.
`define TWL_ASSERT_IMPL(lbl, ante, cons, msg) \
  `TWL_ASSERT(lbl, ((ante) |-> (cons)), msg)

`endif

// ===== rtl/core/twl_pkg.sv =====
// Shared constants and codes of the timed wait list.
`timescale 1ns / 1ps
package twl_pkg;

  localparam int unsigned TWL_DEPTH = 16;

  localparam int unsigned KindW = 2;
  localparam int unsigned TidW  = 16;
  localparam int unsigned TmoW  = 16;
  localparam int unsigned ResW  = 3;
  localparam int unsigned OccW  = 5;

  // Input item kinds
  localparam logic [KindW-1:0] KIND_ADD    = 2'd0;
  localparam logic [KindW-1:0] KIND_TICK   = 2'd1;
  localparam logic [KindW-1:0] KIND_POP    = 2'd2;
  localparam logic [KindW-1:0] KIND_REMOVE = 2'd3;

  // Result item kinds
  localparam logic [ResW-1:0] RES_ADDED     = 3'd0;
  localparam logic [ResW-1:0] RES_FULL      = 3'd1;
  localparam logic [ResW-1:0] RES_TIMED_OUT = 3'd2;
  localparam logic [ResW-1:0] RES_POPPED    = 3'd3;
  localparam logic [ResW-1:0] RES_EMPTY     = 3'd4;
  localparam logic [ResW-1:0] RES_REMOVED   = 3'd5;
  localparam logic [ResW-1:0] RES_NOT_FOUND = 3'd6;

endpackage

// ===== rtl/core/timed_wait_list.sv =====
// Timed wait list: ordered list of blocked threads with per-entry tick timeouts.
`timescale 1ns / 1ps
// The list lives compacted in one RAM (thread id and remaining ticks per
// entry, head at slot 0) with a registered read. An add writes its entry
// as it is accepted. A tick, pop or remove streams every stored entry
// through the single RAM read port once, reading slot r while writing kept
// entries back to slot w <= r. The walk pauses while a second release
// waits behind a full output register. A tick that releases nothing gives
// no result; every other item gives at least one, and the final result of
// an item has last set. No clearing pass is needed after reset.
module timed_wait_list
  import twl_pkg::*;
#(
  parameter int unsigned DEPTH = TWL_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [KindW-1:0] kind_i,
  input  logic [TidW-1:0]  thread_id_i,
  input  logic [TmoW-1:0]  timeout_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ResW-1:0]  result_kind_o,
  output logic [TidW-1:0]  thread_id_out_o,
  output logic [OccW-1:0]  occupancy_o,
  output logic             last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = TidW + TmoW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [KindW-1:0] op_q, op_d;
  logic [TidW-1:0]  tid_q, tid_d;
  logic [CW-1:0]    n_q, n_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    rp_q, rp_d;
  logic [CW-1:0]    wp_q, wp_d;
  logic             found_q, found_d;

  logic             pend_valid_q, pend_valid_d;
  logic [ResW-1:0]  pend_kind_q, pend_kind_d;
  logic [TidW-1:0]  pend_tid_q, pend_tid_d;
  logic [OccW-1:0]  pend_occ_q, pend_occ_d;

  logic             out_valid_q, out_valid_d;
  logic [ResW-1:0]  out_kind_q, out_kind_d;
  logic [TidW-1:0]  out_tid_q, out_tid_d;
  logic [OccW-1:0]  out_occ_q, out_occ_d;
  logic             out_last_q, out_last_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [DW-1:0]    ram_wdata, ram_rdata;

  logic [TidW-1:0]  ent_tid;
  logic [TmoW-1:0]  ent_ticks, new_ticks;
  logic [CW-1:0]    rp_inc, cnt_dec;
  logic             out_free, in_walk, drop, blocked, advance, accept;
  logic             has_room;
  logic [ResW-1:0]  drop_kind;

  assign ent_tid   = ram_rdata[DW-1:TmoW];
  assign ent_ticks = ram_rdata[TmoW-1:0];
  assign rp_inc    = rp_q + CW'(1);
  assign cnt_dec   = cnt_q - CW'(1);
  assign has_room  = (cnt_q < CW'(DEPTH));

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_walk    = (state_q == ST_WALK) && (rp_q != n_q);

  always_comb begin
    drop      = 1'b0;
    drop_kind = RES_TIMED_OUT;
    case (op_q)
      KIND_TICK: begin
        drop      = (ent_ticks == TmoW'(1));
        drop_kind = RES_TIMED_OUT;
      end
      KIND_POP: begin
        drop      = (rp_q == '0);
        drop_kind = RES_POPPED;
      end
      KIND_REMOVE: begin
        drop      = !found_q && (ent_tid == tid_q);
        drop_kind = RES_REMOVED;
      end
      default: begin
        drop      = 1'b0;
        drop_kind = RES_TIMED_OUT;
      end
    endcase
  end

  // A second release needs the pending result moved out first.
  assign blocked = drop && pend_valid_q && !out_free;
  assign advance = in_walk && !blocked;

  assign new_ticks = ((op_q == KIND_TICK) && (ent_ticks != '0)) ? ent_ticks - TmoW'(1)
                                                                 : ent_ticks;

  always_comb begin
    if (state_q == ST_START) begin
      ram_raddr = '0;
    end else if (advance) begin
      ram_raddr = rp_inc[AW-1:0];
    end else begin
      ram_raddr = rp_q[AW-1:0];
    end
  end

  always_comb begin
    if (state_q == ST_IDLE) begin
      ram_we    = accept && (kind_i == KIND_ADD) && has_room;
      ram_waddr = cnt_q[AW-1:0];
      ram_wdata = {thread_id_i, timeout_i};
    end else begin
      ram_we    = advance && !drop;
      ram_waddr = wp_q[AW-1:0];
      ram_wdata = {ent_tid, new_ticks};
    end
  end

  twl_ram #(
    .Width (DW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    tid_d        = tid_q;
    n_d          = n_q;
    cnt_d        = cnt_q;
    rp_d         = rp_q;
    wp_d         = wp_q;
    found_d      = found_q;
    pend_valid_d = pend_valid_q;
    pend_kind_d  = pend_kind_q;
    pend_tid_d   = pend_tid_q;
    pend_occ_d   = pend_occ_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_tid_d    = out_tid_q;
    out_occ_d    = out_occ_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = kind_i;
          tid_d = thread_id_i;
          if (kind_i == KIND_ADD) begin
            pend_valid_d = 1'b1;
            pend_tid_d   = thread_id_i;
            if (has_room) begin
              cnt_d       = cnt_q + CW'(1);
              pend_kind_d = RES_ADDED;
              pend_occ_d  = OccW'(cnt_q + CW'(1));
            end else begin
              pend_kind_d = RES_FULL;
              pend_occ_d  = OccW'(cnt_q);
            end
            state_d = ST_FIN;
          end else begin
            n_d     = cnt_q;
            rp_d    = '0;
            wp_d    = '0;
            found_d = 1'b0;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (rp_q == n_q) begin
          state_d = ST_FIN;
        end else if (advance) begin
          rp_d = rp_inc;
          if (drop) begin
            cnt_d   = cnt_dec;
            found_d = 1'b1;
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_kind_d  = pend_kind_q;
              out_tid_d   = pend_tid_q;
              out_occ_d   = pend_occ_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_kind_d  = drop_kind;
            pend_tid_d   = ent_tid;
            pend_occ_d   = OccW'(cnt_dec);
          end else begin
            wp_d = wp_q + CW'(1);
          end
        end
      end
      ST_FIN: begin
        if (pend_valid_q) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_kind_d   = pend_kind_q;
            out_tid_d    = pend_tid_q;
            out_occ_d    = pend_occ_q;
            out_last_d   = 1'b1;
            pend_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end else if ((op_q == KIND_POP) || (op_q == KIND_REMOVE)) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_kind_d  = (op_q == KIND_POP) ? RES_EMPTY : RES_NOT_FOUND;
            out_tid_d   = (op_q == KIND_POP) ? '0 : tid_q;
            out_occ_d   = OccW'(cnt_q);
            out_last_d  = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          // Tick that released nothing: drop silently
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    tid_q       <= tid_d;
    n_q         <= n_d;
    rp_q        <= rp_d;
    wp_q        <= wp_d;
    found_q     <= found_d;
    pend_kind_q <= pend_kind_d;
    pend_tid_q  <= pend_tid_d;
    pend_occ_q  <= pend_occ_d;
    out_kind_q  <= out_kind_d;
    out_tid_q   <= out_tid_d;
    out_occ_q   <= out_occ_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_kind_q;
  assign thread_id_out_o = out_tid_q;
  assign occupancy_o     = out_occ_q;
  assign last_o          = out_last_q;

endmodule

// ===== rtl/core/twl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module twl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/twl_checker.sv =====
// Port-level assertion checker for the timed wait list, bound to the top level.
`timescale 1ns / 1ps
`include "timed_wait_list_macros.svh"

module twl_checker
  import twl_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [ResW-1:0]  result_kind_o,
  input logic [TidW-1:0]  thread_id_out_o,
  input logic [OccW-1:0]  occupancy_o,
  input logic             last_o
);

  `TWL_ASSERT(a_out_hold, (out_valid_o && !out_ready_i |=> out_valid_o), "result item dropped while stalled")
  `TWL_ASSERT(a_one_at_a_time, (in_valid_i && in_ready_o |=> !in_ready_o), "second item taken while one is in work")
  `TWL_ASSERT_IMPL(a_kind_legal, out_valid_o, result_kind_o <= RES_NOT_FOUND, "illegal result kind")
  `TWL_ASSERT_IMPL(a_single_last, out_valid_o && (result_kind_o != RES_TIMED_OUT), last_o, "single-result item without last")
  `TWL_ASSERT_IMPL(a_empty_zero, out_valid_o && (result_kind_o == RES_EMPTY), (thread_id_out_o == '0) && (occupancy_o == '0), "empty result with nonzero fields")

endmodule

bind timed_wait_list twl_checker u_twl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .result_kind_o   (result_kind_o),
  .thread_id_out_o (thread_id_out_o),
  .occupancy_o     (occupancy_o),
  .last_o          (last_o)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the timed wait list: directed table plus random items.
`timescale 1ns / 1ps
module tb_top;
  import twl_pkg::*;

  localparam int RandItems   = 300;
  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = TWL_DEPTH + 8;
  localparam int NumRows     = 24;

  typedef struct packed {
    logic [ResW-1:0] kind;
    logic [TidW-1:0] tid;
    logic [OccW-1:0] occ;
    logic            last;
  } wait_res_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [TidW-1:0]  tid;
    logic [TmoW-1:0]  tmo;
    logic [4:0]       reps;
    logic             typed;
    wait_res_t        res;
  } stim_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             out_ready_i = 1'b0;
  logic [KindW-1:0] kind_i      = '0;
  logic [TidW-1:0]  thread_id_i = '0;
  logic [TmoW-1:0]  timeout_i   = '0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [ResW-1:0]  result_kind_o;
  logic [TidW-1:0]  thread_id_out_o;
  logic [OccW-1:0]  occupancy_o;
  logic             last_o;

  timed_wait_list #(
    .DEPTH(TWL_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .thread_id_i    (thread_id_i),
    .timeout_i      (timeout_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .thread_id_out_o(thread_id_out_o),
    .occupancy_o    (occupancy_o),
    .last_o         (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Shadow copy of the wait list, head at slot 0.
  logic [TidW-1:0] wl_tid   [TWL_DEPTH];
  logic [TmoW-1:0] wl_ticks [TWL_DEPTH];
  int              wl_cnt = 0;

  wait_res_t pending_results[$];
  stim_row_t dir_rows [NumRows];
  int        errors     = 0;
  int        items_done = 0;
  int        idle_cycles = 0;
  logic      calm;

  // Hold both sides busy through one stretch of the run.
  assign calm = (items_done >= 150) && (items_done < 210);

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic drop_slot(input int pos);
    for (int j = pos; j + 1 < wl_cnt; j++) begin
      wl_tid[j]   = wl_tid[j + 1];
      wl_ticks[j] = wl_ticks[j + 1];
    end
    if (wl_cnt > 0) wl_cnt--;
  endtask

  task automatic predict_wait_list(input logic [KindW-1:0] kind, input logic [TidW-1:0] tid,
                                   input logic [TmoW-1:0] tmo, input bit log_it);
    wait_res_t       burst[$];
    wait_res_t       tail_res;
    logic [TidW-1:0] rel;
    int              i;
    int              pos;
    bit              released;
    case (kind)
      KIND_ADD: begin
        if (wl_cnt < TWL_DEPTH) begin
          wl_tid[wl_cnt]   = tid;
          wl_ticks[wl_cnt] = tmo;
          wl_cnt++;
          burst.push_back('{RES_ADDED, tid, OccW'(wl_cnt), 1'b1});
        end else begin
          burst.push_back('{RES_FULL, tid, OccW'(wl_cnt), 1'b1});
        end
      end
      KIND_TICK: begin
        i = 0;
        while (i < wl_cnt) begin
          released = 1'b0;
          if (wl_ticks[i] != '0) begin
            wl_ticks[i] = wl_ticks[i] - 1'b1;
            if (wl_ticks[i] == '0) begin
              rel = wl_tid[i];
              drop_slot(i);
              burst.push_back('{RES_TIMED_OUT, rel, OccW'(wl_cnt), 1'b0});
              released = 1'b1;
            end
          end
          // A released slot now holds its successor; look at it again.
          if (!released) i++;
        end
        if (burst.size() > 0) begin
          tail_res = burst.pop_back();
          tail_res.last = 1'b1;
          burst.push_back(tail_res);
        end
      end
      KIND_POP: begin
        if (wl_cnt > 0) begin
          rel = wl_tid[0];
          drop_slot(0);
          burst.push_back('{RES_POPPED, rel, OccW'(wl_cnt), 1'b1});
        end else begin
          burst.push_back('{RES_EMPTY, '0, '0, 1'b1});
        end
      end
      default: begin
        pos = -1;
        for (i = 0; i < wl_cnt; i++) begin
          if (pos < 0 && wl_tid[i] == tid) pos = i;
        end
        if (pos >= 0) begin
          drop_slot(pos);
          burst.push_back('{RES_REMOVED, tid, OccW'(wl_cnt), 1'b1});
        end else begin
          burst.push_back('{RES_NOT_FOUND, tid, OccW'(wl_cnt), 1'b1});
        end
      end
    endcase
    if (log_it) begin
      foreach (burst[k]) pending_results.push_back(burst[k]);
    end
  endtask

  // Alternate fill-heavy and drain-heavy phases; short timeouts so ticks release.
  task automatic pick_random(input int idx, output logic [KindW-1:0] kind,
                             output logic [TidW-1:0] tid, output logic [TmoW-1:0] tmo);
    int r;
    int add_w;
    int tsel;
    add_w = ((idx / 40) % 2 == 0) ? 60 : 30;
    r = $urandom_range(0, 99);
    if (r < add_w) kind = KIND_ADD;
    else if (r < add_w + (100 - add_w) / 2) kind = KIND_TICK;
    else if (r < add_w + 3 * (100 - add_w) / 4) kind = KIND_POP;
    else kind = KIND_REMOVE;
    if ($urandom_range(0, 1) == 0) tid = TidW'($urandom);
    else tid = TidW'($urandom_range(0, 7));
    if (kind == KIND_REMOVE && wl_cnt > 0 && $urandom_range(0, 9) < 7) begin
      tid = wl_tid[$urandom_range(0, wl_cnt - 1)];
    end
    tsel = $urandom_range(0, 9);
    if (tsel < 6) tmo = TmoW'($urandom_range(1, 4));
    else if (tsel < 8) tmo = '0;
    else tmo = TmoW'($urandom);
  endtask

  initial begin : drive_proc
    int              row_idx;
    int              rep_idx;
    int              rand_count;
    bit              loaded;
    bit              held;
    bit              done;
    bit              cur_typed;
    wait_res_t       cur_res;
    bit              nxt_typed;
    wait_res_t       nxt_res;
    logic [KindW-1:0] nk;
    logic [TidW-1:0]  nt;
    logic [TmoW-1:0]  nm;
    dir_rows = '{
      '{KIND_POP,    16'h0000, 16'h0000, 5'd1,  1'b1, '{RES_EMPTY, 16'h0000, 5'd0, 1'b1}},
      '{KIND_TICK,   16'h0000, 16'h0000, 5'd1,  1'b0, '0},
      '{KIND_REMOVE, 16'hffff, 16'h0000, 5'd1,  1'b1, '{RES_NOT_FOUND, 16'hffff, 5'd0, 1'b1}},
      '{KIND_ADD,    16'hffff, 16'h0000, 5'd1,  1'b1, '{RES_ADDED, 16'hffff, 5'd1, 1'b1}},
      '{KIND_ADD,    16'h0000, 16'hffff, 5'd1,  1'b1, '{RES_ADDED, 16'h0000, 5'd2, 1'b1}},
      '{KIND_ADD,    16'h5555, 16'h0001, 5'd1,  1'b1, '{RES_ADDED, 16'h5555, 5'd3, 1'b1}},
      '{KIND_ADD,    16'haaaa, 16'h0001, 5'd1,  1'b1, '{RES_ADDED, 16'haaaa, 5'd4, 1'b1}},
      '{KIND_ADD,    16'h5555, 16'h0002, 5'd1,  1'b1, '{RES_ADDED, 16'h5555, 5'd5, 1'b1}},
      '{KIND_TICK,   16'h0000, 16'h0000, 5'd1,  1'b0, '0},
      '{KIND_ADD,    16'h0001, 16'h0000, 5'd1,  1'b1, '{RES_ADDED, 16'h0001, 5'd4, 1'b1}},
      '{KIND_ADD,    16'h0001, 16'h0000, 5'd1,  1'b1, '{RES_ADDED, 16'h0001, 5'd5, 1'b1}},
      '{KIND_REMOVE, 16'h0001, 16'h0000, 5'd1,  1'b0, '0},
      '{KIND_REMOVE, 16'h1234, 16'h0000, 5'd1,  1'b0, '0},
      '{KIND_ADD,    16'h0100, 16'h0003, 5'd12, 1'b0, '0},
      '{KIND_ADD,    16'hbeef, 16'h0007, 5'd1,  1'b1, '{RES_FULL, 16'hbeef, 5'd16, 1'b1}},
      '{KIND_TICK,   16'h0000, 16'h0000, 5'd1,  1'b0, '0},
      '{KIND_ADD,    16'h7fff, 16'h8000, 5'd1,  1'b0, '0},
      '{KIND_TICK,   16'hffff, 16'hffff, 5'd1,  1'b0, '0},
      '{KIND_TICK,   16'h0000, 16'h0000, 5'd1,  1'b0, '0},
      '{KIND_POP,    16'hffff, 16'hffff, 5'd1,  1'b0, '0},
      '{KIND_REMOVE, 16'h7fff, 16'h0000, 5'd1,  1'b0, '0},
      '{KIND_REMOVE, 16'h0000, 16'h0000, 5'd1,  1'b0, '0},
      '{KIND_POP,    16'h0000, 16'h0000, 5'd1,  1'b0, '0},
      '{KIND_POP,    16'h0000, 16'h0000, 5'd1,  1'b0, '0}
    };
    row_idx    = 0;
    rep_idx    = 0;
    rand_count = 0;
    loaded     = 1'b0;
    done       = 1'b0;
    cur_typed  = 1'b0;
    cur_res    = '0;
    nxt_typed  = 1'b0;
    nxt_res    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!done) begin
      @(posedge clk_i);
      held = in_valid_i && !in_ready_o;
      if (in_valid_i && in_ready_o) begin
        predict_wait_list(kind_i, thread_id_i, timeout_i, !cur_typed);
        if (cur_typed) pending_results.push_back(cur_res);
        items_done++;
      end
      if (!held) begin
        if (!loaded) begin
          if (row_idx < NumRows) begin
            nk        = dir_rows[row_idx].kind;
            nt        = dir_rows[row_idx].tid + TidW'(rep_idx);
            nm        = dir_rows[row_idx].tmo;
            nxt_typed = dir_rows[row_idx].typed;
            nxt_res   = dir_rows[row_idx].res;
            rep_idx++;
            if (rep_idx >= dir_rows[row_idx].reps) begin
              row_idx++;
              rep_idx = 0;
            end
            loaded = 1'b1;
          end else if (rand_count < RandItems) begin
            pick_random(rand_count, nk, nt, nm);
            nxt_typed = 1'b0;
            nxt_res   = '0;
            rand_count++;
            loaded = 1'b1;
          end
        end
        if (loaded && (calm || $urandom_range(0, 99) >= 21)) begin
          in_valid_i  <= 1'b1;
          kind_i      <= nk;
          thread_id_i <= nt;
          timeout_i   <= nm;
          cur_typed   = nxt_typed;
          cur_res     = nxt_res;
          loaded      = 1'b0;
        end else begin
          in_valid_i <= 1'b0;
          if (!loaded) done = 1'b1;
        end
      end
    end
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(posedge clk_i) begin : result_mon
    wait_res_t got;
    wait_res_t want;
    if (rst_ni) begin
      out_ready_i <= calm || ($urandom_range(0, 99) >= 21);
      if (out_valid_o && out_ready_i) begin
        got = '{result_kind_o, thread_id_out_o, occupancy_o, last_o};
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d tid=%h occ=%0d last=%b",
                                    got.kind, got.tid, got.occ, got.last));
        end else begin
          want = pending_results.pop_front();
          if (got.kind != want.kind || got.tid != want.tid || got.occ != want.occ ||
              got.last != want.last) begin
            report_mismatch($sformatf(
              "got kind=%0d tid=%h occ=%0d last=%b, want kind=%0d tid=%h occ=%0d last=%b",
              got.kind, got.tid, got.occ, got.last,
              want.kind, want.tid, want.occ, want.last));
          end
        end
      end
    end
    // Watchdog: stop when neither channel moves an item for too long.
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
